/* sv/uwfv_pkg.sv */
package uwfv_pkg;

    // default number format of the velocity words
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration port
    localparam int CFG_WIDTH       = 31;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EDGE_MODE      = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_COURANT   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ZERO_TOLERANCE = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_BOUNDARY   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_BOUNDARY  = 3'd4;

    // boundary rules
    localparam logic [1:0] BND_INTERIOR = 2'd0;
    localparam logic [1:0] BND_INFLOW   = 2'd1;
    localparam logic [1:0] BND_WALL     = 2'd2;
    localparam logic [1:0] BND_OUTFLOW  = 2'd3;

    // face kinds
    localparam logic [1:0] FACE_INTERIOR = 2'd0;
    localparam logic [1:0] FACE_LOW      = 2'd1;
    localparam logic [1:0] FACE_HIGH     = 2'd2;

    typedef struct packed {
        logic                 edge_mode;
        logic [CFG_WIDTH-1:0] half_courant;
        logic [CFG_WIDTH-1:0] zero_tolerance;
        logic [1:0]           low_boundary;
        logic [1:0]           high_boundary;
    } cfg_t;

endpackage

/* sv/upwind_face_velocity_top.sv */
// Upwind face velocity, one cell face per word, signed fixed point with FRAC_BITS
// fraction bits (Q16.16 by default). A face word enters when in_valid and in_ready
// are both high and its velocity leaves through the five register stages; a new
// face can be taken every cycle while out_ready is high; while a finished result
// waits, free stages still take words until all are full. Latency is set by the
// two chained multiplications of the slope form (courant factor times full
// velocity, then weight times slope), each followed by its own rescaling stage,
// and by the final exact-sum upwind stage; throughput is one face per cycle while
// out_ready is high. Configuration registers are written through
// cfg_write/cfg_index/cfg_data and should only change while no face is in flight.
module upwind_face_velocity_top #(
    parameter int DATA_WIDTH = uwfv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = uwfv_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_write,
    input  logic [uwfv_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [uwfv_pkg::CFG_WIDTH-1:0]         cfg_data,
    // face words in
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [DATA_WIDTH-1:0]           cell_left,
    input  logic signed [DATA_WIDTH-1:0]           cell_right,
    input  logic signed [DATA_WIDTH-1:0]           full_left,
    input  logic signed [DATA_WIDTH-1:0]           full_right,
    input  logic signed [DATA_WIDTH-1:0]           left_aux,
    input  logic signed [DATA_WIDTH-1:0]           right_aux,
    input  logic signed [DATA_WIDTH-1:0]           base_vel,
    input  logic signed [DATA_WIDTH-1:0]           ghost_vel,
    input  logic [1:0]                             face_kind,
    // upwinded velocity out
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [DATA_WIDTH-1:0]           face_vel
);

    uwfv_pkg::cfg_t cfg_reg;

    logic                           mid_valid;
    logic                           mid_ready;
    logic [6*DATA_WIDTH+1:0]        mid_carry;
    logic signed [2*DATA_WIDTH-1:0] mid_prod_left;
    logic signed [2*DATA_WIDTH-1:0] mid_prod_right;

    // register file: unknown indexes are ignored, oversized values keep their low bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                uwfv_pkg::REG_EDGE_MODE:      cfg_reg.edge_mode      <= cfg_data[0];
                uwfv_pkg::REG_HALF_COURANT:   cfg_reg.half_courant   <= cfg_data;
                uwfv_pkg::REG_ZERO_TOLERANCE: cfg_reg.zero_tolerance <= cfg_data;
                uwfv_pkg::REG_LOW_BOUNDARY:   cfg_reg.low_boundary   <= cfg_data[1:0];
                uwfv_pkg::REG_HIGH_BOUNDARY:  cfg_reg.high_boundary  <= cfg_data[1:0];
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // stages 1 to 3: slope weights and weighted slopes
    uwfv_slope #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_slope (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_left  (cell_left),
        .cell_right (cell_right),
        .full_left  (full_left),
        .full_right (full_right),
        .left_aux   (left_aux),
        .right_aux  (right_aux),
        .base_vel   (base_vel),
        .ghost_vel  (ghost_vel),
        .face_kind  (face_kind),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .carry      (mid_carry),
        .prod_left  (mid_prod_left),
        .prod_right (mid_prod_right)
    );

    // stages 4 and 5: edge velocities, boundary rules, upwind choice
    uwfv_resolve #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_resolve (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .carry      (mid_carry),
        .prod_left  (mid_prod_left),
        .prod_right (mid_prod_right),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .face_vel   (face_vel)
    );

`ifndef ASSERT_OFF
    // a result waiting on out_ready stays offered with its value unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(face_vel)))
        else $error("stalled result dropped or changed");
`endif

endmodule

/* sv/uwfv_slope.sv */
module uwfv_slope #(
    parameter int DATA_WIDTH = uwfv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = uwfv_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  uwfv_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [DATA_WIDTH-1:0]   cell_left,
    input  logic signed [DATA_WIDTH-1:0]   cell_right,
    input  logic signed [DATA_WIDTH-1:0]   full_left,
    input  logic signed [DATA_WIDTH-1:0]   full_right,
    input  logic signed [DATA_WIDTH-1:0]   left_aux,
    input  logic signed [DATA_WIDTH-1:0]   right_aux,
    input  logic signed [DATA_WIDTH-1:0]   base_vel,
    input  logic signed [DATA_WIDTH-1:0]   ghost_vel,
    input  logic [1:0]                     face_kind,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [6*DATA_WIDTH+1:0]        carry,
    output logic signed [2*DATA_WIDTH-1:0] prod_left,
    output logic signed [2*DATA_WIDTH-1:0] prod_right
);

    localparam int DW  = DATA_WIDTH;
    localparam int PW1 = DW + uwfv_pkg::CFG_WIDTH + 1;
    localparam int CW  = 6 * DW + 2;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW:0]   HALF = (DW+1)'(1) << (FRAC_BITS - 1);

    // carry word: {cell_left, cell_right, left_aux, right_aux, base_vel, ghost_vel, face_kind}
    logic [CW-1:0] c1_reg, c2_reg, c3_reg;
    logic          v1_reg, v2_reg, v3_reg;
    logic          rdy1, rdy2, rdy3;

    logic signed [DW-1:0]  fl_clip, fr_clip;
    logic signed [PW1-1:0] p1l_next, p1r_next, p1l_reg, p1r_reg;
    logic signed [PW1-1:0] sh1l, sh1r;
    logic signed [DW-1:0]  m1l, m1r;
    logic signed [DW:0]    dl, dr;
    logic signed [DW-1:0]  facl_next, facr_next, facl_reg, facr_reg;
    logic signed [DW-1:0]  la2, ra2;
    logic signed [2*DW-1:0] p2l_next, p2r_next, p2l_reg, p2r_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: courant factor times clipped full velocity
    assign fl_clip  = full_left[DW-1]  ? '0 : full_left;
    assign fr_clip  = full_right[DW-1] ? full_right : '0;
    assign p1l_next = $signed({1'b0, cfg.half_courant}) * fl_clip;
    assign p1r_next = $signed({1'b0, cfg.half_courant}) * fr_clip;

    // stage 2: rescale, saturate, form the slope weights
    assign sh1l = p1l_reg >>> FRAC_BITS;
    assign sh1r = p1r_reg >>> FRAC_BITS;

    always_comb
    begin
        if ((&sh1l[PW1-1:DW-1]) || !(|sh1l[PW1-1:DW-1]))
        begin
            m1l = sh1l[DW-1:0];
        end
        else
        begin
            m1l = sh1l[PW1-1] ? MINV : MAXV;
        end
        if ((&sh1r[PW1-1:DW-1]) || !(|sh1r[PW1-1:DW-1]))
        begin
            m1r = sh1r[DW-1:0];
        end
        else
        begin
            m1r = sh1r[PW1-1] ? MINV : MAXV;
        end
        dl = HALF - {m1l[DW-1], m1l};
        dr = HALF + {m1r[DW-1], m1r};
        if (dl[DW] != dl[DW-1])
        begin
            facl_next = dl[DW] ? MINV : MAXV;
        end
        else
        begin
            facl_next = dl[DW-1:0];
        end
        if (dr[DW] != dr[DW-1])
        begin
            facr_next = dr[DW] ? MINV : MAXV;
        end
        else
        begin
            facr_next = dr[DW-1:0];
        end
    end

    // stage 3: weight times slope
    assign la2      = c2_reg[4*DW+1:3*DW+2];
    assign ra2      = c2_reg[3*DW+1:2*DW+2];
    assign p2l_next = facl_reg * la2;
    assign p2r_next = facr_reg * ra2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            c1_reg  <= {cell_left, cell_right, left_aux, right_aux, base_vel, ghost_vel,
                        face_kind};
            p1l_reg <= p1l_next;
            p1r_reg <= p1r_next;
        end
        if (rdy2 && v1_reg)
        begin
            c2_reg   <= c1_reg;
            facl_reg <= facl_next;
            facr_reg <= facr_next;
        end
        if (rdy3 && v2_reg)
        begin
            c3_reg  <= c2_reg;
            p2l_reg <= p2l_next;
            p2r_reg <= p2r_next;
        end
    end

    assign out_valid  = v3_reg;
    assign carry      = c3_reg;
    assign prod_left  = p2l_reg;
    assign prod_right = p2r_reg;

`ifndef ASSERT_OFF
    // back-pressure only reaches the input once every stage is occupied
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input blocked with a free stage");

    // a stalled final stage keeps its word
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !out_ready) |=> (v3_reg && $stable(p2l_reg) && $stable(p2r_reg)))
        else $error("stage 3 word lost under stall");
`endif

endmodule

/* sv/uwfv_resolve.sv */
module uwfv_resolve #(
    parameter int DATA_WIDTH = uwfv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = uwfv_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  uwfv_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [6*DATA_WIDTH+1:0]        carry,
    input  logic signed [2*DATA_WIDTH-1:0] prod_left,
    input  logic signed [2*DATA_WIDTH-1:0] prod_right,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [DATA_WIDTH-1:0]   face_vel
);

    localparam int DW   = DATA_WIDTH;
    localparam int SW   = DW + 3;
    localparam int CMPW = (SW > uwfv_pkg::CFG_WIDTH) ? SW : uwfv_pkg::CFG_WIDTH;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    logic signed [DW-1:0]   cl, cr, la, ra, w, gv;
    logic [1:0]             kind;
    logic signed [2*DW-1:0] shl, shr;
    logic signed [DW-1:0]   m2l, m2r;
    logic signed [DW:0]     sl, sr;
    logic signed [DW-1:0]   ul0, ur0, ul_next, ur_next;

    logic signed [DW-1:0]   ul_reg, ur_reg, w4_reg, face_vel_reg;
    logic [1:0]             kind4_reg;
    logic                   v4_reg, v5_reg;
    logic                   rdy4, rdy5;

    logic signed [DW:0]     a, b;
    logic signed [SW-1:0]   s;
    logic [SW-1:0]          mag;
    logic                   stag, near, pos;
    logic signed [DW-1:0]   res_next;

    assign {cl, cr, la, ra, w, gv, kind} = carry;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    // stage 4: edge velocities and boundary rules
    assign shl = prod_left >>> FRAC_BITS;
    assign shr = prod_right >>> FRAC_BITS;

    always_comb
    begin
        if ((&shl[2*DW-1:DW-1]) || !(|shl[2*DW-1:DW-1]))
        begin
            m2l = shl[DW-1:0];
        end
        else
        begin
            m2l = shl[2*DW-1] ? MINV : MAXV;
        end
        if ((&shr[2*DW-1:DW-1]) || !(|shr[2*DW-1:DW-1]))
        begin
            m2r = shr[DW-1:0];
        end
        else
        begin
            m2r = shr[2*DW-1] ? MINV : MAXV;
        end
        sl = {cl[DW-1], cl} + {m2l[DW-1], m2l};
        sr = {cr[DW-1], cr} - {m2r[DW-1], m2r};
        if (cfg.edge_mode)
        begin
            ul0 = la;
            ur0 = ra;
        end
        else
        begin
            ul0 = (sl[DW] != sl[DW-1]) ? (sl[DW] ? MINV : MAXV) : sl[DW-1:0];
            ur0 = (sr[DW] != sr[DW-1]) ? (sr[DW] ? MINV : MAXV) : sr[DW-1:0];
        end

        ul_next = ul0;
        ur_next = ur0;
        if (kind == uwfv_pkg::FACE_LOW)
        begin
            unique case (cfg.low_boundary)
                uwfv_pkg::BND_INFLOW:
                begin
                    ul_next = cl;
                    ur_next = cl;
                end
                uwfv_pkg::BND_WALL:
                begin
                    ul_next = '0;
                    ur_next = '0;
                end
                uwfv_pkg::BND_OUTFLOW:
                begin
                    ul_next = ur0[DW-1] ? ur0 : '0;
                    ur_next = ur0[DW-1] ? ur0 : '0;
                end
                default:
                begin
                    ul_next = ul0;
                    ur_next = ur0;
                end
            endcase
        end
        else if (kind == uwfv_pkg::FACE_HIGH)
        begin
            unique case (cfg.high_boundary)
                uwfv_pkg::BND_INFLOW:
                begin
                    ul_next = gv;
                    ur_next = gv;
                end
                uwfv_pkg::BND_WALL:
                begin
                    ul_next = '0;
                    ur_next = '0;
                end
                uwfv_pkg::BND_OUTFLOW:
                begin
                    ul_next = ul0[DW-1] ? '0 : ul0;
                    ur_next = ul0[DW-1] ? '0 : ul0;
                end
                default:
                begin
                    ul_next = ul0;
                    ur_next = ur0;
                end
            endcase
        end
    end

    // stage 5: upwind choice on exact sums
    assign a    = {ul_reg[DW-1], ul_reg} + {w4_reg[DW-1], w4_reg};
    assign b    = {ur_reg[DW-1], ur_reg} + {w4_reg[DW-1], w4_reg};
    assign s    = SW'(ul_reg) + SW'(ur_reg) + (SW'(w4_reg) <<< 1);
    assign mag  = s[SW-1] ? (~s + 1'b1) : s;
    assign stag = (a <= 0) && (b >= 0);
    assign near = CMPW'(mag) < CMPW'(cfg.zero_tolerance);
    assign pos  = !s[SW-1] && (|s);

    assign res_next = (stag || near) ? '0 : (pos ? ul_reg : ur_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
            begin
                v4_reg <= in_valid;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && in_valid)
        begin
            ul_reg    <= ul_next;
            ur_reg    <= ur_next;
            w4_reg    <= w;
            kind4_reg <= kind;
        end
        if (rdy5 && v4_reg)
        begin
            face_vel_reg <= res_next;
        end
    end

    assign out_valid = v5_reg;
    assign face_vel  = face_vel_reg;

`ifndef ASSERT_OFF
    // a wall at the low face always yields a zero velocity
    a_low_wall_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && rdy5 && kind4_reg == uwfv_pkg::FACE_LOW
         && cfg.low_boundary == uwfv_pkg::BND_WALL) |=> (face_vel == '0))
        else $error("low wall face gave non-zero velocity");

    // high outflow never lets a negative velocity through
    a_high_outflow_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && rdy5 && kind4_reg == uwfv_pkg::FACE_HIGH
         && cfg.high_boundary == uwfv_pkg::BND_OUTFLOW) |=> !face_vel[DW-1])
        else $error("high outflow face gave negative velocity");
`endif

endmodule

/* verif/upwind_face_checker.sv */
`timescale 1ns / 1ps

module upwind_face_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [uwfv_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [uwfv_pkg::CFG_WIDTH-1:0]          cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic signed [uwfv_pkg::DATA_WIDTH_DEF-1:0] cell_left,
    input  logic signed [uwfv_pkg::DATA_WIDTH_DEF-1:0] cell_right,
    input  logic signed [uwfv_pkg::DATA_WIDTH_DEF-1:0] full_left,
    input  logic signed [uwfv_pkg::DATA_WIDTH_DEF-1:0] full_right,
    input  logic signed [uwfv_pkg::DATA_WIDTH_DEF-1:0] left_aux,
    input  logic signed [uwfv_pkg::DATA_WIDTH_DEF-1:0] right_aux,
    input  logic signed [uwfv_pkg::DATA_WIDTH_DEF-1:0] base_vel,
    input  logic signed [uwfv_pkg::DATA_WIDTH_DEF-1:0] ghost_vel,
    input  logic [1:0]                              face_kind,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [uwfv_pkg::DATA_WIDTH_DEF-1:0] face_vel,
    output int                                      mismatches,
    output int                                      faces_in_flight
);

    localparam int     DW      = uwfv_pkg::DATA_WIDTH_DEF;
    localparam int     FB      = uwfv_pkg::FRAC_BITS_DEF;
    localparam longint VEL_MAX = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint VEL_MIN = -VEL_MAX - 1;

    uwfv_pkg::cfg_t       regs_copy = '0;
    logic signed [DW-1:0] expected_face_vel [$];

    function automatic longint saturate(input longint v);
        if (v > VEL_MAX)
            return VEL_MAX;
        if (v < VEL_MIN)
            return VEL_MIN;
        return v;
    endfunction

    // exact product, floor rescale, clamp
    function automatic longint fixed_mul(input longint a, input longint b);
        return saturate((a * b) >>> FB);
    endfunction

    function automatic logic signed [DW-1:0] upwind_velocity(
        input longint     cl, cr, fl, fr, la, ra, w, gv,
        input logic [1:0] kind
    );
        longint ul;
        longint ur;
        longint fac_l;
        longint fac_r;
        longint total;
        bit     stagnant;

        if (regs_copy.edge_mode)
        begin
            ul = la;
            ur = ra;
        end
        else
        begin
            fac_l = saturate((longint'(1) <<< (FB - 1))
                             - fixed_mul(longint'(regs_copy.half_courant), (fl > 0) ? fl : 0));
            fac_r = saturate((longint'(1) <<< (FB - 1))
                             + fixed_mul(longint'(regs_copy.half_courant), (fr < 0) ? fr : 0));
            ul = saturate(cl + fixed_mul(fac_l, la));
            ur = saturate(cr - fixed_mul(fac_r, ra));
        end

        if (kind == uwfv_pkg::FACE_LOW)
        begin
            case (regs_copy.low_boundary)
                uwfv_pkg::BND_INFLOW:  begin ul = cl; ur = cl; end
                uwfv_pkg::BND_WALL:    begin ul = 0;  ur = 0;  end
                uwfv_pkg::BND_OUTFLOW: begin ul = (ur < 0) ? ur : 0; ur = ul; end
                default: ;
            endcase
        end
        else if (kind == uwfv_pkg::FACE_HIGH)
        begin
            case (regs_copy.high_boundary)
                uwfv_pkg::BND_INFLOW:  begin ul = gv; ur = gv; end
                uwfv_pkg::BND_WALL:    begin ul = 0;  ur = 0;  end
                uwfv_pkg::BND_OUTFLOW: begin ul = (ul > 0) ? ul : 0; ur = ul; end
                default: ;
            endcase
        end

        total    = ul + ur + 2 * w;
        stagnant = (ul + w <= 0) && (ur + w >= 0);
        if (((total < 0) ? -total : total) < longint'(regs_copy.zero_tolerance))
            stagnant = 1'b1;
        if (stagnant)
            return '0;
        return (total > 0) ? DW'(ul) : DW'(ur);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic signed [DW-1:0] want;
        if (!rst_n)
        begin
            regs_copy = '0;
            expected_face_vel.delete();
            mismatches      = 0;
            faces_in_flight = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_face_vel.push_back(upwind_velocity(
                    longint'(cell_left), longint'(cell_right),
                    longint'(full_left), longint'(full_right),
                    longint'(left_aux), longint'(right_aux),
                    longint'(base_vel), longint'(ghost_vel), face_kind));

            if (out_valid && out_ready)
            begin
                if (expected_face_vel.size() == 0)
                begin
                    $error("face_vel with no face in flight: expected none, got %0d", face_vel);
                    mismatches++;
                end
                else
                begin
                    want = expected_face_vel.pop_front();
                    if (face_vel !== want)
                    begin
                        $error("face_vel mismatch: expected %0d, got %0d", want, face_vel);
                        mismatches++;
                    end
                end
            end

            // register writes must land while idle; the DUT does not enforce it
            if (cfg_write)
            begin
                case (cfg_index)
                    uwfv_pkg::REG_EDGE_MODE:      regs_copy.edge_mode      = cfg_data[0];
                    uwfv_pkg::REG_HALF_COURANT:   regs_copy.half_courant   = cfg_data;
                    uwfv_pkg::REG_ZERO_TOLERANCE: regs_copy.zero_tolerance = cfg_data;
                    uwfv_pkg::REG_LOW_BOUNDARY:   regs_copy.low_boundary   = cfg_data[1:0];
                    uwfv_pkg::REG_HIGH_BOUNDARY:  regs_copy.high_boundary  = cfg_data[1:0];
                    default: ;
                endcase
            end

            faces_in_flight = expected_face_vel.size();
        end
    end

endmodule

/* verif/upwind_face_velocity_top_tb.sv */
`timescale 1ns / 1ps

module upwind_face_velocity_top_tb;

    localparam int DW          = uwfv_pkg::DATA_WIDTH_DEF;
    localparam int CW          = uwfv_pkg::CFG_WIDTH;
    localparam int IW          = uwfv_pkg::CFG_INDEX_WIDTH;
    // five register stages between a face word and its velocity
    localparam int PIPE_DEPTH  = 5;
    // long enough for the pipeline to fill and push back on the sender
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 12;
    localparam int PHASE_FACES = 150;

    localparam logic signed [DW-1:0] VEL_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VEL_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE     = 1 << uwfv_pkg::FRAC_BITS_DEF;
    localparam logic [CW-1:0]        CFG_ALL = '1;

    // indexes past the last register, writes there must be dropped
    localparam logic [IW-1:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [IW-1:0] REG_UNUSED_LAST  = 3'd7;

    // kind of back-pressure exercised within a phase
    typedef enum int {NO_PRESSURE, HOLD_RECEIVER, PAUSE_SENDER} pressure_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [IW-1:0]        cfg_index = '0;
    logic [CW-1:0]        cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic signed [DW-1:0] cell_left  = '0;
    logic signed [DW-1:0] cell_right = '0;
    logic signed [DW-1:0] full_left  = '0;
    logic signed [DW-1:0] full_right = '0;
    logic signed [DW-1:0] left_aux   = '0;
    logic signed [DW-1:0] right_aux  = '0;
    logic signed [DW-1:0] base_vel   = '0;
    logic signed [DW-1:0] ghost_vel  = '0;
    logic [1:0]           face_kind  = uwfv_pkg::FACE_INTERIOR;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [DW-1:0] face_vel;

    int mismatches;
    int faces_in_flight;

    // idling switches, flipped per phase by the stimulus
    bit tx_gaps     = 1'b0;
    bit rx_stalls   = 1'b0;
    bit rx_hold_req = 1'b0;

    upwind_face_velocity_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_left  (cell_left),
        .cell_right (cell_right),
        .full_left  (full_left),
        .full_right (full_right),
        .left_aux   (left_aux),
        .right_aux  (right_aux),
        .base_vel   (base_vel),
        .ghost_vel  (ghost_vel),
        .face_kind  (face_kind),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .face_vel   (face_vel)
    );

    // watches both channels and the register port, predicts and compares
    upwind_face_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cell_left       (cell_left),
        .cell_right      (cell_right),
        .full_left       (full_left),
        .full_right      (full_right),
        .left_aux        (left_aux),
        .right_aux       (right_aux),
        .base_vel        (base_vel),
        .ghost_vel       (ghost_vel),
        .face_kind       (face_kind),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .face_vel        (face_vel),
        .mismatches      (mismatches),
        .faces_in_flight (faces_in_flight)
    );

    // 12 ns period
    always #6 clk = ~clk;

    // hard stop well beyond the slowest legal run
    initial
    begin : watchdog
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // receiver side: random stall bursts, plus one long hold-off on request
    initial
    begin : receiver
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (rx_stalls && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // offer one face word from a falling edge, hold it until taken,
    // then maybe leave a gap; returns on a falling edge
    task automatic offer_face(
        input logic signed [DW-1:0] cl, cr, fl, fr, la, ra, w, gv,
        input logic [1:0]           kind
    );
        in_valid   <= 1'b1;
        cell_left  <= cl;
        cell_right <= cr;
        full_left  <= fl;
        full_right <= fr;
        left_aux   <= la;
        right_aux  <= ra;
        base_vel   <= w;
        ghost_vel  <= gv;
        face_kind  <= kind;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (tx_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    // velocity mix: rails, full-range noise, and mostly modest values
    // so that signs vary and the upwind decision is not trivial
    function automatic logic signed [DW-1:0] rand_vel();
        int pick;
        pick = $urandom_range(0, 11);
        if (pick == 0)
            return VEL_MAX;
        if (pick == 1)
            return VEL_MIN;
        if (pick < 5)
            return $urandom;
        return int'($urandom_range(0, 1 << 21)) - (1 << 20);
    endfunction

    task automatic random_face();
        logic [1:0] kind;
        // the spare face kind now and then, otherwise the three real ones
        kind = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        offer_face(rand_vel(), rand_vel(), rand_vel(), rand_vel(),
                   rand_vel(), rand_vel(), rand_vel(), rand_vel(), kind);
    endtask

    // sender stops and waits until every predicted velocity has come back
    task automatic await_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (faces_in_flight != 0)
            @(negedge clk);
    endtask

    task automatic settle_pipeline();
        await_results();
        repeat (2 * PIPE_DEPTH) @(negedge clk);
    endtask

    // leaves the write enable high; the caller lowers it after the last one
    task automatic write_reg(
        input logic [IW-1:0] idx,
        input logic [CW-1:0] value
    );
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [CW-1:0] em, hc, tol, lo, hi);
        write_reg(uwfv_pkg::REG_EDGE_MODE, em);
        write_reg(uwfv_pkg::REG_HALF_COURANT, hc);
        write_reg(uwfv_pkg::REG_ZERO_TOLERANCE, tol);
        write_reg(uwfv_pkg::REG_LOW_BOUNDARY, lo);
        write_reg(uwfv_pkg::REG_HIGH_BOUNDARY, hi);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [CW-1:0] pick_courant();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_ALL;
            2:       return CW'(ONE >>> 1);
            3:       return CW'(ONE);
            default: return CW'($urandom_range(0, 32'h2_0000));
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_tolerance();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_ALL;
            2:       return CW'(1);
            default: return CW'($urandom_range(0, 32'h4_0000));
        endcase
    endfunction

    // one block of random faces under fresh settings; raw random words go to
    // the narrow registers so their upper bits are exercised too
    task automatic run_phase(input int count, input bit tx, rx, input pressure_t pressure);
        int i;
        settle_pipeline();
        apply_settings(CW'($urandom), pick_courant(), pick_tolerance(),
                       CW'($urandom), CW'($urandom));
        tx_gaps   = tx;
        rx_stalls = rx;
        for (i = 0; i < count; i++)
        begin
            if (i == count / 2 && pressure == HOLD_RECEIVER)
                rx_hold_req = 1'b1;
            if (i == count / 2 && pressure == PAUSE_SENDER)
                await_results();
            random_face();
        end
    endtask

    initial
    begin : stimulus
        int        p;
        pressure_t pressure;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed part ---
        // reset settings: slope mode, zero courant, no tolerance, interior rules
        offer_face(0, 0, 0, 0, 0, 0, 0, 0, uwfv_pkg::FACE_INTERIOR);
        offer_face(VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX,
                   uwfv_pkg::FACE_INTERIOR);
        offer_face(VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN,
                   uwfv_pkg::FACE_INTERIOR);
        offer_face(ONE, ONE, 0, 0, 0, 0, 0, 0, uwfv_pkg::FACE_INTERIOR);
        offer_face(-ONE, -ONE, 0, 0, 0, 0, 0, 0, uwfv_pkg::FACE_INTERIOR);
        // stagnation point: flow diverging from the face
        offer_face(-ONE, ONE, 0, 0, 0, 0, 0, 0, uwfv_pkg::FACE_INTERIOR);
        // spare face kind behaves as interior
        offer_face(2 * ONE, ONE, ONE, -ONE, ONE, ONE, -ONE, 3 * ONE, 2'd3);
        // saturating slope add and subtract
        offer_face(VEL_MAX, VEL_MIN, 0, 0, VEL_MAX, VEL_MAX, VEL_MIN, 0,
                   uwfv_pkg::FACE_INTERIOR);
        // converging flow summing to exactly zero falls to the right state
        offer_face(ONE, -ONE, 0, 0, 0, 0, 0, 0, uwfv_pkg::FACE_INTERIOR);

        // edge states, low inflow, high wall
        settle_pipeline();
        apply_settings(CW'(1), CW'(ONE >>> 1), '0, CW'(uwfv_pkg::BND_INFLOW),
                       CW'(uwfv_pkg::BND_WALL));
        offer_face(3 * ONE, ONE, 0, 0, -5, 7, 0, 0, uwfv_pkg::FACE_LOW);
        offer_face(3 * ONE, ONE, 0, 0, -5, 7, ONE, 0, uwfv_pkg::FACE_HIGH);
        offer_face(0, 0, 0, 0, 2 * ONE, -ONE, 0, 0, uwfv_pkg::FACE_INTERIOR);
        offer_face(VEL_MIN, VEL_MAX, 0, 0, VEL_MAX, VEL_MAX, VEL_MIN, VEL_MAX,
                   uwfv_pkg::FACE_LOW);

        // oversized values for the narrow registers, every wide register at its top,
        // outflow on both sides, and writes to unused indexes
        settle_pipeline();
        apply_settings(CFG_ALL - 1'b1, CFG_ALL, CFG_ALL, CFG_ALL, CFG_ALL);
        write_reg(REG_UNUSED_FIRST, CFG_ALL);
        write_reg(REG_UNUSED_LAST, CW'(1));
        cfg_write <= 1'b0;
        @(negedge clk);
        offer_face(VEL_MAX, VEL_MAX, VEL_MAX, VEL_MIN, 0, 0, VEL_MAX, 0,
                   uwfv_pkg::FACE_INTERIOR);
        offer_face(0, VEL_MIN, 0, 0, 0, 0, VEL_MIN, 0, uwfv_pkg::FACE_LOW);
        offer_face(VEL_MAX, 0, 0, 0, 0, 0, VEL_MAX, 0, uwfv_pkg::FACE_HIGH);
        // courant product and weight product both clip
        offer_face(ONE, -ONE, VEL_MAX, VEL_MIN, VEL_MAX, VEL_MIN, ONE, 0,
                   uwfv_pkg::FACE_INTERIOR);
        // small sum swallowed by the tolerance
        offer_face(ONE, ONE, 0, 0, 0, 0, 0, 0, uwfv_pkg::FACE_INTERIOR);

        // low wall, high inflow, tolerance of one lsb
        settle_pipeline();
        apply_settings(CW'(1), CW'(1), CW'(1), CW'(uwfv_pkg::BND_WALL),
                       CW'(uwfv_pkg::BND_INFLOW));
        offer_face(ONE, ONE, 0, 0, 5 * ONE, 5 * ONE, ONE, 0, uwfv_pkg::FACE_LOW);
        offer_face(0, 0, 0, 0, ONE, ONE, 0, -7 * ONE, uwfv_pkg::FACE_HIGH);
        offer_face(0, 0, 0, 0, 0, 0, VEL_MIN, VEL_MIN, uwfv_pkg::FACE_HIGH);
        offer_face(0, 0, 0, 0, ONE, -ONE, 0, 0, uwfv_pkg::FACE_INTERIOR);

        // slope mode with a unit courant factor, interior rules on domain faces
        settle_pipeline();
        apply_settings('0, CW'(ONE), '0, CW'(uwfv_pkg::BND_INTERIOR),
                       CW'(uwfv_pkg::BND_INTERIOR));
        offer_face(ONE, ONE, 2 * ONE, ONE, ONE, ONE, 0, 0, uwfv_pkg::FACE_LOW);
        offer_face(-ONE, -ONE, ONE, -3 * ONE, ONE, ONE, 0, ONE, uwfv_pkg::FACE_HIGH);

        // --- random part ---
        for (p = 0; p < PHASES; p++)
        begin
            pressure = (p == 4) ? HOLD_RECEIVER : (p == 7) ? PAUSE_SENDER : NO_PRESSURE;
            // last phase runs flat out on both sides
            if (p == PHASES - 1)
                run_phase(PHASE_FACES, 1'b0, 1'b0, pressure);
            else
                run_phase(PHASE_FACES, p % 3 != 2, p % 4 != 3, pressure);
        end

        // drain and give the block time to show any stray word
        settle_pipeline();

        if (mismatches == 0 && faces_in_flight == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
